@@ hdl/pts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes of the periodic task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned DataW = 32;
  localparam logic [DataW-1:0] HalfRange = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CMD_REGISTER  = 3'd0,
    CMD_ADVANCE   = 3'd1,
    CMD_SCAN      = 3'd2,
    CMD_DELAY     = 3'd3,
    CMD_DELAY_ALL = 3'd4,
    CMD_TERMINATE = 3'd5,
    CMD_REWORK    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_FINISH = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    TS_READY      = 2'd0,
    TS_BLOCKED    = 2'd1,
    TS_TERMINATED = 2'd2
  } task_state_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [3:0]       task_id;
    logic [DataW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] task_out;
    logic       status;
    logic       last;
  } out_t;

  // one table slot
  typedef struct packed {
    logic [1:0]       state;
    logic [DataW-1:0] period;
    logic [DataW-1:0] deadline;
  } entry_t;

  // per-field write enables
  typedef struct packed {
    logic state;
    logic period;
    logic deadline;
  } wmask_t;

endpackage
`default_nettype wire

@@ hdl/pts_addsub.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pts_addsub
// Shared 32-bit adder/subtractor with the wrap-safe deadline test.
// ----------------------------------------------------------------------------
module pts_addsub
  import pts_pkg::*;
(
  input  wire logic [DataW-1:0] a_i,
  input  wire logic [DataW-1:0] b_i,
  input  wire logic             sub_i,
  output logic      [DataW-1:0] sum_o,
  output logic                  due_o
);

  assign sum_o = sub_i ? (a_i - b_i) : (a_i + b_i);
  // deadline passed when tick - deadline lands in the lower half
  assign due_o = (sum_o <= HalfRange);

endmodule
`default_nettype wire

@@ hdl/pts_task_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pts_task_ram
// Task table: one write port with field enables, one registered read port.
// ----------------------------------------------------------------------------
module pts_task_ram
  import pts_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire wmask_t           wmask_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire entry_t           wdata_i,
  input  wire logic             re_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output entry_t                rdata_o
);

  logic [1:0]       state_mem    [DEPTH];
  logic [DataW-1:0] period_mem   [DEPTH];
  logic [DataW-1:0] deadline_mem [DEPTH];
  entry_t           rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i && wmask_i.state)    state_mem[waddr_i]    <= wdata_i.state;
    if (we_i && wmask_i.period)   period_mem[waddr_i]   <= wdata_i.period;
    if (we_i && wmask_i.deadline) deadline_mem[waddr_i] <= wdata_i.deadline;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q.state    <= state_mem[raddr_i];
      rdata_q.period   <= period_mem[raddr_i];
      rdata_q.deadline <= deadline_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hdl/periodic_task_scheduler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_scheduler_core
// Cooperative periodic task table with a 32-bit tick, run by a small
// sequencer around one shared adder and a simple dual-port task memory.
// ----------------------------------------------------------------------------
// Path from the accepting edge to the result word entering the output
//   register: register, advance, terminate and unknown codes go straight to
//   the response; delay task and rework read and check a registered id first.
// Delay all: one memory slot per cycle for the tasks walked.
// Scan: every registered task is read and checked, due ready or blocked
//   tasks are re-armed and fired ones send a word; the walk is set by the read,
//   check and re-arm steps on the one adder. Output stalls lengthen every command.
// One word at a time: in_stall_o is high from accept until the last result
//   word is loaded.
// Reset clears tick and task count; table is not cleared.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_core
  import pts_pkg::*;
#(
  parameter int unsigned NUM_TASKS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_word_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_word_o
);

  // CNT_W holds 0..NUM_TASKS, IDX_W addresses a slot
  localparam int unsigned CNT_W = $clog2(NUM_TASKS + 1);
  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_CHK,
    S_SCAN_UPD,
    S_SCAN_NEXT,
    S_ALL_CHK,
    S_ONE_CHK,
    S_RESP
  } state_e;

  state_e           st_q, st_d, ret_q, ret_d;
  logic [2:0]       cmd_q, cmd_d;
  logic [DataW-1:0] value_q, value_d;
  logic [DataW-1:0] tick_q, tick_d;
  logic [CNT_W-1:0] reg_q, reg_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             fire_q, fire_d;
  out_t             resp_q, resp_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  // shared adder
  logic [DataW-1:0] add_b, add_sum;
  logic             add_sub, add_due;

  // task memory port
  logic             mem_we, mem_re;
  wmask_t           mem_wmask;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;

  logic             in_acc;
  logic             can_push;
  logic             known;
  logic             full;
  logic [CNT_W-1:0] idx_inc;
  logic             idx_last;

  assign in_stall_o  = (st_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign can_push    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // id below the count is also below NUM_TASKS
  assign known    = (32'(in_word_i.task_id) < 32'(reg_q));
  assign full     = (reg_q == CNT_W'(NUM_TASKS));
  assign idx_inc  = idx_q + 1'b1;
  assign idx_last = (idx_inc == reg_q);

  pts_addsub u_addsub (
    .a_i   (tick_q),
    .b_i   (add_b),
    .sub_i (add_sub),
    .sum_o (add_sum),
    .due_o (add_due)
  );

  pts_task_ram #(
    .DEPTH (NUM_TASKS),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .wmask_i (mem_wmask),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    st_d        = st_q;
    ret_d       = ret_q;
    cmd_d       = cmd_q;
    value_d     = value_q;
    tick_d      = tick_q;
    reg_d       = reg_q;
    idx_d       = idx_q;
    fire_d      = fire_q;
    resp_d      = resp_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    add_b       = value_q;
    add_sub     = 1'b0;

    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wmask   = '0;
    mem_waddr   = IDX_W'(idx_q);
    mem_raddr   = IDX_W'(idx_q);
    mem_wdata   = mem_rdata;

    case (st_q)
      S_IDLE: begin
        add_b = in_word_i.value;
        if (in_acc) begin
          cmd_d   = in_word_i.cmd;
          value_d = in_word_i.value;
          idx_d   = '0;
          resp_d  = '{kind: KIND_ACK, task_out: 4'd0, status: 1'b0, last: 1'b1};
          ret_d   = S_IDLE;
          st_d    = S_RESP;
          case (in_word_i.cmd)
            CMD_REGISTER: begin
              if (full) begin
                resp_d.status = 1'b1;
              end else begin
                mem_we          = 1'b1;
                mem_wmask       = '{state: 1'b1, period: 1'b1, deadline: 1'b1};
                mem_waddr       = IDX_W'(reg_q);
                mem_wdata       = '{state: TS_READY, period: in_word_i.value,
                                    deadline: in_word_i.value};
                reg_d           = reg_q + 1'b1;
                resp_d.task_out = 4'(reg_q);
              end
            end
            CMD_ADVANCE: begin
              tick_d = add_sum;
            end
            CMD_SCAN: begin
              if (reg_q == '0) begin
                resp_d.kind = KIND_FINISH;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                st_d      = S_SCAN_CHK;
              end
            end
            CMD_DELAY, CMD_REWORK: begin
              if (!known) begin
                resp_d.status = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(in_word_i.task_id);
                idx_d     = CNT_W'(in_word_i.task_id);
                st_d      = S_ONE_CHK;
              end
            end
            CMD_DELAY_ALL: begin
              if (reg_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                st_d      = S_ALL_CHK;
              end
            end
            CMD_TERMINATE: begin
              if (!known) begin
                resp_d.status = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_wmask = '{state: 1'b1, period: 1'b0, deadline: 1'b1};
                mem_waddr = IDX_W'(in_word_i.task_id);
                mem_wdata = '{state: TS_TERMINATED, period: '0, deadline: '0};
              end
            end
            default: begin
              resp_d.status = 1'b1;
            end
          endcase
        end
      end

      // tick - deadline, then decide on re-arm
      S_SCAN_CHK: begin
        add_sub = 1'b1;
        add_b   = mem_rdata.deadline;
        fire_d  = (mem_rdata.state == TS_READY);
        if (add_due && (mem_rdata.state == TS_READY ||
                        mem_rdata.state == TS_BLOCKED)) begin
          st_d = S_SCAN_UPD;
        end else begin
          st_d = S_SCAN_NEXT;
        end
      end

      // deadline = tick + period, state back to ready
      S_SCAN_UPD: begin
        add_b              = mem_rdata.period;
        mem_we             = 1'b1;
        mem_wmask          = '{state: 1'b1, period: 1'b0, deadline: 1'b1};
        mem_wdata.state    = TS_READY;
        mem_wdata.deadline = add_sum;
        if (fire_q) begin
          resp_d = '{kind: KIND_FIRED, task_out: 4'(idx_q), status: 1'b0, last: 1'b0};
          ret_d  = S_SCAN_NEXT;
          st_d   = S_RESP;
        end else begin
          st_d = S_SCAN_NEXT;
        end
      end

      S_SCAN_NEXT: begin
        idx_d = idx_inc;
        if (idx_last) begin
          resp_d = '{kind: KIND_FINISH, task_out: 4'd0, status: 1'b0, last: 1'b1};
          ret_d  = S_IDLE;
          st_d   = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(idx_inc);
          st_d      = S_SCAN_CHK;
        end
      end

      // block slot idx (stop with error on a terminated one), read the next one in the same cycle
      S_ALL_CHK: begin
        add_b = value_q;
        if (mem_rdata.state == TS_TERMINATED) begin
          resp_d.status = 1'b1;
          ret_d         = S_IDLE;
          st_d          = S_RESP;
        end else begin
          mem_we             = 1'b1;
          mem_wmask          = '{state: 1'b1, period: 1'b0, deadline: 1'b1};
          mem_wdata.state    = TS_BLOCKED;
          mem_wdata.deadline = add_sum;
          idx_d              = idx_inc;
          if (idx_last) begin
            ret_d = S_IDLE;
            st_d  = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = IDX_W'(idx_inc);
          end
        end
      end

      S_ONE_CHK: begin
        st_d = S_RESP;
        if (cmd_q == CMD_DELAY) begin
          add_b = value_q;
          if (mem_rdata.state == TS_TERMINATED) begin
            resp_d.status = 1'b1;
          end else begin
            mem_we             = 1'b1;
            mem_wmask          = '{state: 1'b1, period: 1'b0, deadline: 1'b1};
            mem_wdata.state    = TS_BLOCKED;
            mem_wdata.deadline = add_sum;
          end
        end else begin
          add_b              = mem_rdata.period;
          mem_we             = 1'b1;
          mem_wmask          = '{state: 1'b1, period: 1'b0, deadline: 1'b1};
          mem_wdata.state    = TS_READY;
          mem_wdata.deadline = add_sum;
        end
      end

      // hand the pending word to the output register
      S_RESP: begin
        if (can_push) begin
          out_valid_d = 1'b1;
          out_d       = resp_q;
          st_d        = ret_q;
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      ret_q       <= S_IDLE;
      tick_q      <= '0;
      reg_q       <= '0;
      idx_q       <= '0;
      fire_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ret_q       <= ret_d;
      tick_q      <= tick_d;
      reg_q       <= reg_d;
      idx_q       <= idx_d;
      fire_q      <= fire_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    value_q <= value_d;
    resp_q  <= resp_d;
    out_q   <= out_d;
  end

  // task count never exceeds the table
  a_reg_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(reg_q) <= NUM_TASKS)
    else $error("task count beyond table depth");

  // a successful registration bumps the count by one
  a_reg_inc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.cmd == CMD_REGISTER && !full)
      |=> (reg_q == CNT_W'($past(reg_q) + 1'b1)))
    else $error("registration did not advance task count");

  // tick moves only on an accepted advance
  a_tick_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_q != $past(tick_q))
      |-> $past(in_acc && in_word_i.cmd == CMD_ADVANCE))
    else $error("tick changed outside advance");

  // acknowledge and finish words always close the command
  a_last_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.kind != KIND_FIRED) |-> out_word_o.last)
    else $error("closing word without last");

  // a walk index stays inside the registered range
  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_SCAN_CHK || st_q == S_SCAN_UPD || st_q == S_ALL_CHK)
      |-> (idx_q < reg_q))
    else $error("walk index out of range");

endmodule
`default_nettype wire
